### hw/rtl/motor_move_ramp_controller_defines.svh
// Assertion macros for the motor move ramp controller.
`ifndef MOTOR_MOVE_RAMP_CONTROLLER_DEFINES_SVH
`define MOTOR_MOVE_RAMP_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
`define MMRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MMRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MMRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/mmrc_pkg.sv
`timescale 1ns / 1ps
package mmrc_pkg;

  localparam int POS_WIDTH_DEF   = 16;
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int RPM_NUM_W       = 16;
  localparam int SPEED_W         = 20;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // Function codes of an input item
  localparam logic [3:0] FN_EDGE     = 4'd0;
  localparam logic [3:0] FN_TICK     = 4'd1;
  localparam logic [3:0] FN_MOVE     = 4'd2;
  localparam logic [3:0] FN_FASTER   = 4'd3;
  localparam logic [3:0] FN_SLOWER   = 4'd4;
  localparam logic [3:0] FN_STOP_ALL = 4'd5;
  localparam logic [3:0] FN_FORWARD  = 4'd6;
  localparam logic [3:0] FN_REVERSE  = 4'd7;
  localparam logic [3:0] FN_GO       = 4'd8;
  localparam logic [3:0] FN_STOP     = 4'd9;

  // Ramp phase codes
  localparam logic [1:0] RAMP_NONE = 2'd0;
  localparam logic [1:0] RAMP_UP   = 2'd1;
  localparam logic [1:0] RAMP_DOWN = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUM     = 3'd6;

  // Configuration reset values
  localparam logic [7:0]           MIN_DUTY_RST    = 8'd52;
  localparam logic [7:0]           STOP_WIN_RST    = 8'd3;
  localparam logic [7:0]           UP_TICKS_RST    = 8'd5;
  localparam logic [7:0]           DOWN_TICKS_RST  = 8'd1;
  localparam logic [7:0]           DUTY_CAP_RST    = 8'd254;
  localparam logic [7:0]           LED_PERIOD_RST  = 8'd24;
  localparam logic [RPM_NUM_W-1:0] RPM_NUM_RST     = 16'd9600;

  localparam logic [7:0]         DUTY_TOP  = 8'd255;
  localparam logic [SPEED_W-1:0] RPM_LIMIT = 20'hFFFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/mmrc_divider.sv
`timescale 1ns / 1ps
module mmrc_divider
  import mmrc_pkg::*;
#(
  parameter int DIV_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DIV_W-1:0] rem_o
);

  localparam int CntW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quot_q, quot_d, dsr_q, dsr_d;
  logic [DIV_W:0]   rem_q, rem_d, shifted, trial;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  assign shifted = {rem_q[DIV_W-1:0], quot_q[DIV_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    priority if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle, restore on a negative trial
      if (!trial[DIV_W]) begin
        rem_d  = trial;
        quot_d = {quot_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q[DIV_W-1:0];

endmodule

### hw/rtl/motor_move_ramp_controller.sv
`timescale 1ns / 1ps
`include "motor_move_ramp_controller_defines.svh"
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid_i / in_ready_o   | func, move_amount, move_direction, edge_time
// result   | out       | out_valid_o / out_ready_i | duty, enable, direction, led, position,
//          |           |                           | goal, rpm, ramp phase
// config   | in        | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One item at a time; in_ready_o is high only while the sequencer is idle.
// A tick or command passes through the execute and window steps, then the rpm division when the edge
// period is increasing, then the output step; a tach edge adds an LED modulo division before that. DIV_W is
// the largest of POSITION_WIDTH, TIMER_WIDTH and 16, one radix-2 quotient bit a cycle.
// A waiting result does not block the next acceptance; that item holds at its end.
// Reset puts all configuration registers and controller state to their defaults.
module motor_move_ramp_controller
  import mmrc_pkg::*;
#(
  parameter int POSITION_WIDTH = POS_WIDTH_DEF,
  parameter int TIMER_WIDTH    = TIMER_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [3:0]                       func_i,
  input  logic signed [15:0]               move_amount_i,
  input  logic                             move_direction_i,
  input  logic [TIMER_WIDTH-1:0]           edge_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       pwm_duty_o,
  output logic                             drive_enable_o,
  output logic                             drive_forward_o,
  output logic                             led_level_o,
  output logic signed [POSITION_WIDTH-1:0] position_o,
  output logic signed [POSITION_WIDTH-1:0] goal_position_o,
  output logic [SPEED_W-1:0]               speed_rpm_o,
  output logic [1:0]                       ramp_phase_o,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]            cfg_wdata_i
);

  localparam int PW    = POSITION_WIDTH;
  localparam int TW    = TIMER_WIDTH;
  localparam int DivW0 = (PW > TW) ? PW : TW;
  localparam int DivW  = (DivW0 > RPM_NUM_W) ? DivW0 : RPM_NUM_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_WINDOW   = 6'b000100,
    S_LED_WAIT = 6'b001000,
    S_RPM_WAIT = 6'b010000,
    S_OUT      = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [7:0]           min_duty_q, stop_win_q, up_ticks_q, down_ticks_q;
  logic [7:0]           duty_cap_q, led_period_q;
  logic [RPM_NUM_W-1:0] rpm_num_q;

  // controller state
  logic [7:0]    duty_q, duty_d, ramp_goal_q, ramp_goal_d, tick_q, tick_d;
  logic          en_q, en_d, fwd_q, fwd_d, led_q, led_d, rpm_on_q, rpm_on_d;
  logic [1:0]    ramp_q, ramp_d;
  logic [PW-1:0] pos_q, pos_d, tgt_q, tgt_d;
  logic [TW-1:0] prev_t_q, prev_t_d, last_t_q, last_t_d;

  // latched item
  logic [3:0]         func_q;
  logic signed [15:0] amount_q;
  logic               dir_q;
  logic [TW-1:0]      etime_q;

  // result register
  logic               out_valid_q, out_valid_d, out_load;
  logic [7:0]         out_duty_q;
  logic               out_en_q, out_fwd_q, out_led_q;
  logic [PW-1:0]      out_pos_q, out_tgt_q;
  logic [SPEED_W-1:0] out_speed_q, speed_val;
  logic [1:0]         out_ramp_q;

  // divider
  logic            div_start;
  logic [DivW-1:0] div_dividend, div_divisor, div_quot, div_rem;
  div_stat_t       div_stat;

  // datapath helpers
  logic signed [15:0] amt_adj, amt_div;
  logic signed [17:0] goal_sum;
  logic [7:0]         move_goal, tick_per, tick_next, duty_base, duty_fast, duty_inc;
  logic [PW:0]        dist_diff, dist_abs;
  logic [PW-1:0]      pos_mag;
  logic [7:0]         led_per;
  logic               rpm_go, led_sel;
  logic [21:0]        quot22, speed_prod;

  assign in_ready_o = (state_q == S_IDLE);

  // move goal: amount / 16 toward zero, offset by the minimum duty
  always_comb begin
    amt_adj  = amount_q + (amount_q[15] ? 16'sd15 : 16'sd0);
    amt_div  = amt_adj >>> 4;
    goal_sum = 18'(amt_div) + $signed(18'(min_duty_q));
    if (goal_sum > 18'sd255) begin
      move_goal = duty_cap_q;
    end else begin
      move_goal = goal_sum[7:0];
      if (move_goal == DUTY_TOP) begin
        move_goal = duty_cap_q;
      end
    end
  end

  always_comb begin
    tick_per  = (ramp_q == RAMP_UP) ? up_ticks_q : down_ticks_q;
    if (tick_per == 8'd0) begin
      tick_per = 8'd1;
    end
    tick_next = tick_q + 8'd1;
    duty_inc  = (duty_q < ramp_goal_q) ? duty_q + 8'd1 : duty_q;
    duty_base = (duty_q < min_duty_q) ? min_duty_q : duty_q;
    duty_fast = (duty_base == DUTY_TOP) ? DUTY_TOP : duty_base + 8'd1;
  end

  always_comb begin
    dist_diff = {pos_q[PW-1], pos_q} - {tgt_q[PW-1], tgt_q};
    dist_abs  = dist_diff[PW] ? (~dist_diff + 1'b1) : dist_diff;
    pos_mag   = pos_q[PW-1] ? (~pos_q + 1'b1) : pos_q;
    led_per   = (led_period_q == 8'd0) ? 8'd1 : led_period_q;
    rpm_go    = (last_t_q > prev_t_q);
  end

  // divider operands: LED modulo on a tach edge, then the rpm quotient
  always_comb begin
    led_sel = (state_q == S_WINDOW) && (func_q == FN_EDGE);
    if (led_sel) begin
      div_dividend = DivW'(pos_mag);
      div_divisor  = DivW'(led_per);
    end else begin
      div_dividend = DivW'(rpm_num_q);
      div_divisor  = DivW'(last_t_q - prev_t_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    duty_d      = duty_q;
    en_d        = en_q;
    fwd_d       = fwd_q;
    led_d       = led_q;
    ramp_d      = ramp_q;
    ramp_goal_d = ramp_goal_q;
    tick_d      = tick_q;
    pos_d       = pos_q;
    tgt_d       = tgt_q;
    prev_t_d    = prev_t_q;
    last_t_d    = last_t_q;
    rpm_on_d    = rpm_on_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_WINDOW;
        unique case (func_q)
          FN_EDGE: begin
            pos_d    = fwd_q ? pos_q + 1'b1 : pos_q - 1'b1;
            prev_t_d = last_t_q;
            last_t_d = etime_q;
          end
          FN_TICK: begin
            if (ramp_q == RAMP_UP || ramp_q == RAMP_DOWN) begin
              if (tick_next < tick_per) begin
                tick_d = tick_next;
              end else begin
                tick_d = 8'd0;
                if (ramp_q == RAMP_UP) begin
                  duty_d = duty_inc;
                  if (duty_inc >= ramp_goal_q) begin
                    ramp_d = RAMP_NONE;
                  end
                end else if (duty_q > min_duty_q) begin
                  duty_d = duty_q - 8'd1;
                end else begin
                  en_d   = 1'b0;
                  ramp_d = RAMP_NONE;
                end
              end
            end
          end
          FN_MOVE: begin
            pos_d  = '0;
            tgt_d  = PW'(amount_q);
            fwd_d  = dir_q;
            en_d   = 1'b1;
            ramp_d = RAMP_NONE;
            // a goal below the minimum duty leaves the duty alone
            if (move_goal >= min_duty_q) begin
              duty_d      = min_duty_q;
              ramp_goal_d = move_goal;
              tick_d      = 8'd0;
              if (min_duty_q < move_goal) begin
                ramp_d = RAMP_UP;
              end
            end
          end
          FN_FASTER: begin
            duty_d = duty_fast;
            if (ramp_q == RAMP_UP && duty_fast >= ramp_goal_q) begin
              ramp_d = RAMP_NONE;
            end
          end
          FN_SLOWER: begin
            duty_d = (duty_q <= min_duty_q) ? min_duty_q : duty_q - 8'd1;
          end
          FN_STOP_ALL: begin
            duty_d = min_duty_q;
            en_d   = 1'b0;
            ramp_d = RAMP_NONE;
          end
          FN_FORWARD: fwd_d = 1'b1;
          FN_REVERSE: fwd_d = 1'b0;
          FN_GO: begin
            tgt_d = {1'b0, {(PW-1){1'b1}}};
            en_d  = 1'b1;
          end
          FN_STOP: begin
            en_d   = 1'b0;
            ramp_d = RAMP_NONE;
          end
          default: ;
        endcase
      end
      S_WINDOW: begin
        if (en_q && ramp_q == RAMP_NONE && dist_abs <= (PW+1)'(stop_win_q)) begin
          if (duty_q < min_duty_q) begin
            en_d = 1'b0;
          end else begin
            ramp_d = RAMP_DOWN;
            tick_d = 8'd0;
          end
        end
        if (led_sel) begin
          div_start = 1'b1;
          state_d   = S_LED_WAIT;
        end else begin
          div_start = rpm_go;
          rpm_on_d  = rpm_go;
          state_d   = rpm_go ? S_RPM_WAIT : S_OUT;
        end
      end
      S_LED_WAIT: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            led_d = ~led_q;
          end
          div_start = rpm_go;
          rpm_on_d  = rpm_go;
          state_d   = rpm_go ? S_RPM_WAIT : S_OUT;
        end
      end
      S_RPM_WAIT: begin
        if (div_stat.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // quotient times 60, saturate
  always_comb begin
    quot22     = 22'(div_quot[RPM_NUM_W-1:0]);
    speed_prod = (quot22 << 6) - (quot22 << 2);
    if (!rpm_on_q) begin
      speed_val = '0;
    end else if (speed_prod > 22'(RPM_LIMIT)) begin
      speed_val = RPM_LIMIT;
    end else begin
      speed_val = speed_prod[SPEED_W-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_duty_q   <= MIN_DUTY_RST;
      stop_win_q   <= STOP_WIN_RST;
      up_ticks_q   <= UP_TICKS_RST;
      down_ticks_q <= DOWN_TICKS_RST;
      duty_cap_q   <= DUTY_CAP_RST;
      led_period_q <= LED_PERIOD_RST;
      rpm_num_q    <= RPM_NUM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_DUTY:    min_duty_q   <= cfg_wdata_i[7:0];
        CFG_STOP_WINDOW: stop_win_q   <= cfg_wdata_i[7:0];
        CFG_UP_TICKS:    up_ticks_q   <= cfg_wdata_i[7:0];
        CFG_DOWN_TICKS:  down_ticks_q <= cfg_wdata_i[7:0];
        CFG_DUTY_CAP:    duty_cap_q   <= cfg_wdata_i[7:0];
        CFG_LED_PERIOD:  led_period_q <= cfg_wdata_i[7:0];
        CFG_RPM_NUM:     rpm_num_q    <= cfg_wdata_i[RPM_NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      duty_q      <= MIN_DUTY_RST;
      en_q        <= 1'b0;
      fwd_q       <= 1'b1;
      led_q       <= 1'b0;
      ramp_q      <= RAMP_NONE;
      ramp_goal_q <= 8'd0;
      tick_q      <= 8'd0;
      pos_q       <= '0;
      tgt_q       <= '0;
      prev_t_q    <= '0;
      last_t_q    <= '0;
      rpm_on_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      duty_q      <= duty_d;
      en_q        <= en_d;
      fwd_q       <= fwd_d;
      led_q       <= led_d;
      ramp_q      <= ramp_d;
      ramp_goal_q <= ramp_goal_d;
      tick_q      <= tick_d;
      pos_q       <= pos_d;
      tgt_q       <= tgt_d;
      prev_t_q    <= prev_t_d;
      last_t_q    <= last_t_d;
      rpm_on_q    <= rpm_on_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q   <= func_i;
      amount_q <= move_amount_i;
      dir_q    <= move_direction_i;
      etime_q  <= edge_time_i;
    end
    if (out_load) begin
      out_duty_q  <= duty_q;
      out_en_q    <= en_q;
      out_fwd_q   <= fwd_q;
      out_led_q   <= led_q;
      out_pos_q   <= pos_q;
      out_tgt_q   <= tgt_q;
      out_speed_q <= speed_val;
      out_ramp_q  <= ramp_q;
    end
  end

  mmrc_divider #(
    .DIV_W(DivW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_valid_o     = out_valid_q;
  assign pwm_duty_o      = out_duty_q;
  assign drive_enable_o  = out_en_q;
  assign drive_forward_o = out_fwd_q;
  assign led_level_o     = out_led_q;
  assign position_o      = out_pos_q;
  assign goal_position_o = out_tgt_q;
  assign speed_rpm_o     = out_speed_q;
  assign ramp_phase_o    = out_ramp_q;

  `MMRC_ASSERT(a_div_start_idle, clk_i, rst_ni, div_start |-> !div_stat.busy, "divider restarted while busy")
  `MMRC_ASSERT(a_ramp_enabled, clk_i, rst_ni, (ramp_q != RAMP_NONE) |-> en_q, "ramp active with motor disabled")
  `MMRC_ASSERT(a_ramp_up_below_goal, clk_i, rst_ni, (ramp_q == RAMP_UP) |-> (duty_q < ramp_goal_q), "ramp-up already at goal")
  `MMRC_ASSERT_NEXT(a_led_hold, clk_i, rst_ni, state_q != S_LED_WAIT, $stable(led_q), "LED changed outside modulo step")

endmodule
